// ----- sv/pcu_pkg.sv -----
`default_nettype none
package pcu_pkg;

  localparam int CPU_SLOTS  = 16;
  localparam int ADDR_W     = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
  localparam int SLOT_W     = 4;
  localparam int SLOT_EXT_W = 8;
  localparam int TICK_W     = 64;
  localparam int N_CNT      = 8;
  localparam int CNT_W      = $clog2(N_CNT);
  localparam int PCT_W      = 7;
  localparam int Q_W        = 8;
  localparam int NUM_W      = TICK_W + Q_W;
  localparam int PCT_SCALE  = 100;
  localparam int PCT_MAX    = 100;

  // counter positions inside one input word
  localparam int IDX_IDLE   = 3;
  localparam int IDX_IOWAIT = 4;

  localparam int IN_W       = SLOT_W + N_CNT * TICK_W;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = SLOT_W + PCT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

endpackage
`default_nettype wire

// ----- sv/pcu_ram.sv -----
`default_nettype none
module pcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/pcu_share.sv -----
`default_nettype none
module pcu_share (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pcu_pkg::TICK_W-1:0]  busy,
  input  wire logic [pcu_pkg::TICK_W-1:0]  tick_span,
  output logic                             done,
  output logic      [pcu_pkg::PCT_W-1:0]   share
);
  import pcu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FIN
  } share_state_t;

  share_state_t       state;
  logic [TICK_W-1:0]  busy_r;
  logic [TICK_W-1:0]  den;
  logic [NUM_W-1:0]   rem;
  logic [NUM_W-1:0]   trial;
  logic [Q_W-1:0]     quo;
  logic [CNT_W-1:0]   step;
  logic [NUM_W-1:0]   prod;
  logic               ge;

  assign prod = NUM_W'(busy_r) * NUM_W'(PCT_SCALE);
  assign ge   = rem >= trial;

  // restoring division, one quotient bit per cycle from the top
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            busy_r <= busy;
            den    <= tick_span;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          rem   <= prod;
          state <= S_ADD;
        end
        S_ADD: begin
          rem   <= rem + NUM_W'(den >> 1);
          trial <= {1'b0, den, (Q_W - 1)'(0)};
          quo   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem <= rem - trial;
          end
          quo   <= {quo[Q_W-2:0], ge};
          trial <= trial >> 1;
          step  <= step + 1'b1;
          if (step == CNT_W'(Q_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          share <= (quo > Q_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : quo[PCT_W-1:0];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/per_cpu_utilization_from_ticks_unit.sv -----
// an accepted word passes the sum, check, eval, share and done states to m_tvalid
// one input word is in work at a time: s_tready is high only in the idle state; the work
//   is the serial sum of the eight counters and the bit-per-cycle divider in pcu_share
// reset: synchronous on rst; clears the control state and the per-slot seen bits, the
//   counter memory is not swept and reads only behind a seen bit
`default_nettype none
module per_cpu_utilization_from_ticks_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // cpu_slot, user, nice, system, idle, iowait, irq, softirq, steal ticks, zero pad
  input  wire logic [pcu_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // result_slot, busy_percent, percent_valid, zero pad
  output logic      [pcu_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import pcu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_EVAL,
    ST_SHARE,
    ST_DONE
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   slot;
  logic [ADDR_W-1:0]   addr;
  logic                in_range;
  logic [TICK_W-1:0]   ticks [N_CNT];
  logic [TICK_W-1:0]   acc;
  logic [TICK_W-1:0]   idle_sum;
  logic [CNT_W-1:0]    idx;
  logic [TICK_W-1:0]   td;
  logic [TICK_W-1:0]   id;
  logic                t_bw;
  logic                i_bw;
  logic [CPU_SLOTS-1:0] seen;
  logic                seen_prev;
  logic                ok;
  logic [SLOT_W-1:0]   out_slot;
  logic [PCT_W-1:0]    out_pct;
  logic                out_ok;
  logic [PCT_W-1:0]    pct;

  logic [SLOT_EXT_W-1:0] in_slot_ext;
  logic                  in_slot_ok;
  logic                  accept;
  logic                  rd_en;
  logic                  wr_en;
  logic [2*TICK_W-1:0]   rd_data;
  logic [TICK_W-1:0]     last_total;
  logic [TICK_W-1:0]     last_idle;
  logic [TICK_W:0]       diff_t;
  logic [TICK_W:0]       diff_i;
  logic                  share_start;
  logic                  share_done;
  logic [PCT_W-1:0]      share;
  logic [TICK_W-1:0]     busy_c;
  logic                  out_free;

  assign in_slot_ext = SLOT_EXT_W'(s_tdata[SLOT_W-1:0]);
  assign in_slot_ok  = in_slot_ext < SLOT_EXT_W'(CPU_SLOTS);
  assign s_tready    = state == ST_IDLE;
  assign accept      = s_tvalid && s_tready;
  assign rd_en       = accept && in_slot_ok;
  assign wr_en       = (state == ST_CHECK) && in_range;

  assign last_total  = rd_data[2*TICK_W-1:TICK_W];
  assign last_idle   = rd_data[TICK_W-1:0];
  assign diff_t      = {1'b0, acc} - {1'b0, last_total};
  assign diff_i      = {1'b0, idle_sum} - {1'b0, last_idle};

  assign share_start = state == ST_EVAL;
  assign busy_c      = td - id;
  assign out_free    = !m_tvalid || m_tready;

  assign m_tdata = OUT_TDATA_W'({out_ok, out_pct, out_slot});

  pcu_ram #(
    .WIDTH (2 * TICK_W),
    .DEPTH (CPU_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data ({acc, idle_sum}),
    .rd_en   (rd_en),
    .rd_addr (in_slot_ext[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  pcu_share u_share (
    .clk       (clk),
    .rst       (rst),
    .start     (share_start),
    .busy      (busy_c),
    .tick_span (td),
    .done      (share_done),
    .share     (share)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      seen     <= '0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            slot     <= s_tdata[SLOT_W-1:0];
            addr     <= in_slot_ext[ADDR_W-1:0];
            in_range <= in_slot_ok;
            for (int i = 0; i < N_CNT; i++) begin
              ticks[i] <= s_tdata[SLOT_W + i*TICK_W +: TICK_W];
            end
            acc   <= '0;
            idx   <= '0;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          // one counter per cycle into the total
          acc <= acc + ticks[idx];
          idx <= idx + 1'b1;
          if (idx == '0) begin
            idle_sum <= ticks[IDX_IDLE] + ticks[IDX_IOWAIT];
          end
          if (idx == CNT_W'(N_CNT - 1)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          td        <= diff_t[TICK_W-1:0];
          id        <= diff_i[TICK_W-1:0];
          t_bw      <= diff_t[TICK_W];
          i_bw      <= diff_i[TICK_W];
          seen_prev <= in_range && seen[addr];
          if (in_range) begin
            seen[addr] <= 1'b1;
          end
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          ok    <= seen_prev && !t_bw && !i_bw && (td != '0) && (id <= td);
          state <= ST_SHARE;
        end
        ST_SHARE: begin
          if (share_done) begin
            pct   <= ok ? share : '0;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_slot <= slot;
            out_pct  <= pct;
            out_ok   <= ok;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word accepted while one is in work");

  a_done_in_share: assert property (@(posedge clk) disable iff (rst)
    share_done |-> state == ST_SHARE)
    else $error("divider finished outside the wait state");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_free |=> m_tvalid && s_tready)
    else $error("finished result not moved to the output register");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[SLOT_W+PCT_W] |-> m_tdata[SLOT_W +: PCT_W] == '0)
    else $error("invalid result with nonzero percent");

endmodule
`default_nettype wire
